// File: rtl/lslc_pkg.sv
package lslc_pkg;

  localparam int MaxSegments = 64;
  localparam int IdxW = $clog2(MaxSegments);
  localparam int CntW = $clog2(MaxSegments + 1);

  localparam logic [31:0] TypeLoad   = 32'd1;
  localparam logic [31:0] TypeTls    = 32'd7;
  localparam logic [31:0] TypeParams = 32'h6100_0001;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_OVERFLOW   = 4'd1,
    ST_ENTRY_MAP  = 4'd2,
    ST_ENTRY_EXEC = 4'd3,
    ST_DUP_PARAMS = 4'd4,
    ST_PARAMS_MAP = 4'd5,
    ST_DUP_TLS    = 4'd6,
    ST_TLS_MAP    = 4'd7,
    ST_TOO_MANY   = 4'd8
  } status_t;

  typedef enum logic [0:0] {
    REG_BIAS         = 1'b0,
    REG_ENTRY_OFFSET = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    DUP_NONE   = 2'd0,
    DUP_PARAMS = 2'd1,
    DUP_TLS    = 2'd2
  } dup_t;

  // which range is under test during a walk
  typedef enum logic [1:0] {
    CHK_ENTRY,
    CHK_EXEC,
    CHK_PARAMS,
    CHK_TLS
  } chk_t;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_WALK,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   start_walk;
    logic   step_walk;
    chk_t   chk;
    logic   clear;
  } cmd_t;

  typedef struct packed {
    logic   walk_done;
    logic   hit;
  } sts_t;

endpackage

// File: rtl/lslc_datapath.sv
module lslc_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_beat,
  input  logic [31:0]            seg_type,
  input  logic [63:0]            seg_vaddr,
  input  logic [63:0]            seg_mem_size,
  input  logic [63:0]            seg_file_size,
  input  logic                   seg_exec,
  input  logic [63:0]            seg_align,
  input  logic                   cfg_we,
  input  logic                   cfg_idx,
  input  logic [63:0]            cfg_data,
  input  lslc_pkg::cmd_t         cmd,
  output lslc_pkg::sts_t         sts,
  output logic                   overflowed,
  output logic                   entry_nz,
  output lslc_pkg::dup_t         dup,
  output logic                   params_seen,
  output logic                   tls_live,
  output logic                   tls_init_nz,
  output logic                   entry_ovf,
  output logic                   params_ovf,
  output logic                   tls_ovf,
  output logic [63:0]            entry_sum,
  output logic [63:0]            params_sum,
  output logic [63:0]            tls_sum,
  output logic [63:0]            tls_init,
  output logic [63:0]            tls_mem_len,
  output logic [63:0]            tls_align_held
);
  import lslc_pkg::*;

  logic [63:0] load_base [MaxSegments];
  logic [63:0] load_length [MaxSegments];
  logic        load_is_exec [MaxSegments];
  logic [CntW-1:0] load_count;
  logic [63:0] image_bias, entry_offset;
  logic [63:0] params_base, params_length, tls_base, tls_file_len;
  logic        tls_seen;
  logic [CntW-1:0] walk_idx;
  logic [63:0] rd_base, rd_len;
  logic        rd_exec, rd_valid, hit;
  logic [63:0] q_addr, q_size, rel;
  logic        q_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bias   <= '0;
      entry_offset <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_BIAS:         image_bias <= cfg_data;
        REG_ENTRY_OFFSET: entry_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && seg_type == TypeLoad && load_count < CntW'(MaxSegments)) begin
      load_base[load_count[IdxW-1:0]]    <= seg_vaddr;
      load_length[load_count[IdxW-1:0]]  <= seg_mem_size;
      load_is_exec[load_count[IdxW-1:0]] <= seg_exec;
    end
    rd_base <= load_base[walk_idx[IdxW-1:0]];
    rd_len  <= load_length[walk_idx[IdxW-1:0]];
    rd_exec <= load_is_exec[walk_idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      load_count  <= '0;
      overflowed  <= 1'b0;
      params_seen <= 1'b0;
      tls_seen    <= 1'b0;
      dup         <= DUP_NONE;
      params_base <= '0; params_length <= '0;
      tls_base <= '0; tls_file_len <= '0; tls_mem_len <= '0; tls_align_held <= '0;
    end else if (in_beat) begin
      priority if (seg_type == TypeLoad) begin
        if (load_count < CntW'(MaxSegments)) load_count <= load_count + 1'b1;
        else overflowed <= 1'b1;
      end else if (seg_type == TypeParams) begin
        if (params_seen) begin
          if (dup == DUP_NONE) dup <= DUP_PARAMS;
        end else begin
          params_seen   <= 1'b1;
          params_base   <= seg_vaddr;
          params_length <= seg_mem_size;
        end
      end else if (seg_type == TypeTls) begin
        if (tls_seen) begin
          if (dup == DUP_NONE) dup <= DUP_TLS;
        end else begin
          tls_seen       <= 1'b1;
          tls_base       <= seg_vaddr;
          tls_file_len   <= seg_file_size;
          tls_mem_len    <= seg_mem_size;
          tls_align_held <= seg_align;
        end
      end else begin
      end
    end
  end

  assign entry_nz    = entry_offset != '0;
  assign tls_live    = tls_seen && tls_mem_len != '0;
  assign tls_init    = (tls_file_len < tls_mem_len) ? tls_file_len : tls_mem_len;
  assign tls_init_nz = tls_init != '0;

  // rebase sums with carry out
  assign {entry_ovf, entry_sum}   = {1'b0, entry_offset} + {1'b0, image_bias};
  assign {params_ovf, params_sum} = {1'b0, params_base} + {1'b0, image_bias};
  assign {tls_ovf, tls_sum}       = {1'b0, tls_base} + {1'b0, image_bias};

  // walker: one stored segment per cycle, read data registered
  always_comb begin
    unique case (cmd.chk)
      CHK_ENTRY:  begin q_addr = entry_offset; q_size = 64'd1; q_exec = 1'b0; end
      CHK_EXEC:   begin q_addr = entry_offset; q_size = 64'd1; q_exec = 1'b1; end
      CHK_PARAMS: begin
        q_addr = params_base;
        q_size = (params_length != '0) ? params_length : 64'd1;
        q_exec = 1'b0;
      end
      default:    begin q_addr = tls_base; q_size = tls_init; q_exec = 1'b0; end
    endcase
  end

  assign rel = q_addr - rd_base;

  always_ff @(posedge clk) begin
    if (rst || cmd.start_walk) begin
      walk_idx <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.step_walk) begin
      if (walk_idx < load_count) walk_idx <= walk_idx + 1'b1;
      rd_valid <= walk_idx < load_count;
      if (rd_valid && q_addr >= rd_base && rel <= rd_len && q_size <= rd_len - rel
          && (!q_exec || rd_exec))
        hit <= 1'b1;
    end
  end

  assign sts.hit       = hit;
  assign sts.walk_done = !rd_valid && walk_idx >= load_count && cmd.step_walk;

endmodule

// File: rtl/lslc_ctrl.sv
module lslc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            last_segment,
  output logic            in_stall,
  output logic            in_beat,
  output logic            out_valid,
  input  logic            out_stall,
  input  lslc_pkg::sts_t  sts,
  output lslc_pkg::cmd_t  cmd,
  input  logic            overflowed,
  input  logic            entry_nz,
  input  lslc_pkg::dup_t  dup,
  input  logic            params_seen,
  input  logic            tls_live,
  input  logic            tls_init_nz,
  input  logic            entry_ovf,
  input  logic            params_ovf,
  input  logic            tls_ovf,
  output logic [3:0]      status,
  output logic            entry_valid,
  output logic            has_params,
  output logic            has_tls
);
  import lslc_pkg::*;

  state_t state, state_next;
  chk_t   chk, chk_next;
  status_t st, st_next;
  logic   he, he_next, hp, hp_next, ht, ht_next;
  logic   walking;

  assign in_stall = state != S_COLLECT;
  assign in_beat  = in_valid && !in_stall;
  assign walking  = state == S_WALK;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COLLECT; chk <= CHK_ENTRY; st <= ST_OK;
      he <= 1'b0; hp <= 1'b0; ht <= 1'b0;
    end else begin
      state <= state_next; chk <= chk_next; st <= st_next;
      he <= he_next; hp <= hp_next; ht <= ht_next;
    end
  end

  // next state, walk target and result flags
  always_comb begin
    state_next = state; chk_next = chk; st_next = st;
    he_next = he; hp_next = hp; ht_next = ht;
    unique case (state)
      S_COLLECT: if (in_beat && last_segment) begin
        state_next = S_DECIDE; chk_next = CHK_ENTRY; st_next = ST_OK;
        he_next = 1'b0; hp_next = 1'b0; ht_next = 1'b0;
      end
      S_WALK: if (sts.walk_done) begin
        state_next = S_DECIDE;
        unique case (chk)
          CHK_ENTRY:
            if (!sts.hit) begin st_next = ST_ENTRY_MAP; state_next = S_OUT; end
            else chk_next = CHK_EXEC;
          CHK_EXEC:
            if (!sts.hit) begin st_next = ST_ENTRY_EXEC; state_next = S_OUT; end
            else if (entry_ovf) begin st_next = ST_OVERFLOW; state_next = S_OUT; end
            else begin he_next = 1'b1; chk_next = CHK_PARAMS; end
          CHK_PARAMS:
            if (!sts.hit) begin st_next = ST_PARAMS_MAP; state_next = S_OUT; end
            else if (params_ovf) begin st_next = ST_OVERFLOW; state_next = S_OUT; end
            else begin hp_next = 1'b1; chk_next = CHK_TLS; end
          default:
            if (!sts.hit) begin st_next = ST_TLS_MAP; state_next = S_OUT; end
            else if (tls_ovf) begin st_next = ST_OVERFLOW; state_next = S_OUT; end
            else begin ht_next = 1'b1; state_next = S_OUT; end
        endcase
      end
      S_DECIDE: begin
        priority if (overflowed) begin st_next = ST_TOO_MANY; state_next = S_OUT; end
        else if (chk == CHK_ENTRY && entry_nz) state_next = S_WALK;
        else if (chk == CHK_EXEC) state_next = S_WALK;
        else if ((chk == CHK_ENTRY || chk == CHK_PARAMS) && dup == DUP_PARAMS) begin
          st_next = ST_DUP_PARAMS; state_next = S_OUT;
        end else if ((chk == CHK_ENTRY || chk == CHK_PARAMS) && dup == DUP_TLS) begin
          st_next = ST_DUP_TLS; state_next = S_OUT;
        end else if ((chk == CHK_ENTRY || chk == CHK_PARAMS) && params_seen) begin
          chk_next = CHK_PARAMS;
          state_next = (chk == CHK_PARAMS) ? S_WALK : S_DECIDE;
        end else if (!tls_live) state_next = S_OUT;
        else if (chk != CHK_TLS) chk_next = CHK_TLS;
        else if (tls_init_nz) state_next = S_WALK;
        else if (tls_ovf) begin st_next = ST_OVERFLOW; state_next = S_OUT; end
        else begin ht_next = 1'b1; state_next = S_OUT; end
      end
      default: if (!out_stall) state_next = S_COLLECT;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.chk = chk;
    cmd.step_walk = walking;
    cmd.start_walk = state == S_DECIDE;
    cmd.clear = state == S_OUT && !out_stall;
  end

  assign out_valid   = state == S_OUT;
  assign status      = st;
  assign entry_valid = he;
  assign has_params  = hp;
  assign has_tls     = ht;

endmodule

// File: rtl/load_segment_launch_checker_core.sv
// Launch checker for the program headers of one image.
// Input channel: one header per beat (in_valid/in_stall); the beat with
// last_segment set closes the image. Output channel (out_valid/out_stall)
// carries one result per image, only after the last header.
// Configuration: cfg_we/cfg_idx/cfg_data write the image bias (0) and
// entry_offset (1); write only while no image is open.
// Throughput: non-final headers are taken one per cycle. After the final
// header the input stalls while stored load segments are walked one per cycle
// from the segment store, in up to four passes (entry, entry exec, params,
// TLS), each pass opened by a decide state. Checks that do not apply are
// skipped.
// The result is held steady while out_stall is high; the input stays
// stalled until the result beat completes, then the image state clears and
// the next header is taken in the following cycle.
// Reset (rst, synchronous) clears the registers and all image state.
// Load headers beyond the 64th in an image set status 8.
module load_segment_launch_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] seg_type,
  input  logic [63:0] seg_vaddr,
  input  logic [63:0] seg_mem_size,
  input  logic [63:0] seg_file_size,
  input  logic        seg_exec,
  input  logic [63:0] seg_align,
  input  logic        last_segment,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        entry_valid,
  output logic [63:0] entry_address,
  output logic        has_params,
  output logic [63:0] params_address,
  output logic        has_tls,
  output logic [63:0] tls_addr,
  output logic [63:0] tls_init_size,
  output logic [63:0] tls_total_size,
  output logic [63:0] tls_align
);
  import lslc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  dup_t dup;
  logic in_beat, overflowed, entry_nz, params_seen, tls_live, tls_init_nz;
  logic entry_ovf, params_ovf, tls_ovf;
  logic [63:0] entry_sum, params_sum, tls_sum, tls_init, tls_mem, tls_al;

  lslc_datapath u_dp (
    .clk, .rst, .in_beat, .seg_type, .seg_vaddr, .seg_mem_size, .seg_file_size,
    .seg_exec, .seg_align, .cfg_we, .cfg_idx, .cfg_data, .cmd, .sts,
    .overflowed, .entry_nz, .dup, .params_seen, .tls_live, .tls_init_nz,
    .entry_ovf, .params_ovf, .tls_ovf, .entry_sum, .params_sum, .tls_sum,
    .tls_init, .tls_mem_len(tls_mem), .tls_align_held(tls_al)
  );

  lslc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .last_segment, .in_stall, .in_beat, .out_valid,
    .out_stall, .sts, .cmd, .overflowed, .entry_nz, .dup, .params_seen,
    .tls_live, .tls_init_nz, .entry_ovf, .params_ovf, .tls_ovf, .status,
    .entry_valid, .has_params, .has_tls
  );

  assign entry_address  = entry_valid ? entry_sum  : '0;
  assign params_address = has_params ? params_sum : '0;
  assign tls_addr       = has_tls ? tls_sum  : '0;
  assign tls_init_size  = has_tls ? tls_init : '0;
  assign tls_total_size = has_tls ? tls_mem  : '0;
  assign tls_align      = has_tls ? tls_al   : '0;

endmodule

// File: rtl/lslc_checker.sv
module lslc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  status,
  input logic        entry_valid,
  input logic        has_tls,
  input logic [63:0] tls_addr
);
  import lslc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped under stall");

  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TOO_MANY)
    else $error("bad status");

  a_tls_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_tls |-> tls_addr == '0)
    else $error("tls address not cleared");

  a_too_many: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_TOO_MANY |-> !entry_valid)
    else $error("fields filled on store overflow");

endmodule

bind load_segment_launch_checker_core lslc_checker u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .status,
  .entry_valid, .has_tls, .tls_addr
);

// File: tb/sv/load_segment_launch_checker_checker.sv
module load_segment_launch_checker_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] seg_type,
  input  logic [63:0] seg_vaddr,
  input  logic [63:0] seg_mem_size,
  input  logic [63:0] seg_file_size,
  input  logic        seg_exec,
  input  logic [63:0] seg_align,
  input  logic        last_segment,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  status,
  input  logic        entry_valid,
  input  logic [63:0] entry_address,
  input  logic        has_params,
  input  logic [63:0] params_address,
  input  logic        has_tls,
  input  logic [63:0] tls_addr,
  input  logic [63:0] tls_init_size,
  input  logic [63:0] tls_total_size,
  input  logic [63:0] tls_align,
  output int          fail_count,
  output int          pending,
  output int          verdicts_seen
);
  import lslc_pkg::*;

  typedef struct packed {
    status_t     st;
    logic        he;
    logic [63:0] ea;
    logic        hp;
    logic [63:0] pa;
    logic        ht;
    logic [63:0] ta;
    logic [63:0] ti;
    logic [63:0] tt;
    logic [63:0] tal;
  } verdict_t;

  verdict_t    verdict_q[$];
  logic [63:0] bias, entry;
  logic [63:0] seg_base[MaxSegments];
  logic [63:0] seg_len[MaxSegments];
  logic        seg_x[MaxSegments];
  int          nseg;
  logic        too_many, p_seen, t_seen;
  logic [63:0] p_base, p_len, t_base, t_file, t_mem, t_align;
  dup_t        dup;

  function automatic logic fits(logic [63:0] addr, logic [63:0] size, logic need_x);
    logic [63:0] rel;
    for (int i = 0; i < nseg; i++) begin
      if (addr < seg_base[i]) continue;
      rel = addr - seg_base[i];
      if (rel > seg_len[i] || size > seg_len[i] - rel) continue;
      if (!need_x || seg_x[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t judge_image();
    verdict_t    v;
    logic [64:0] sum;
    logic [63:0] init;
    v = '0;
    v.st = ST_OK;
    if (too_many) begin
      v.st = ST_TOO_MANY;
      return v;
    end
    if (entry != 0) begin
      if (!fits(entry, 64'd1, 1'b0)) begin v.st = ST_ENTRY_MAP; return v; end
      if (!fits(entry, 64'd1, 1'b1)) begin v.st = ST_ENTRY_EXEC; return v; end
      sum = {1'b0, entry} + {1'b0, bias};
      if (sum[64]) begin v.st = ST_OVERFLOW; return v; end
      v.he = 1'b1;
      v.ea = sum[63:0];
    end
    if (dup == DUP_PARAMS) begin v.st = ST_DUP_PARAMS; return v; end
    if (dup == DUP_TLS) begin v.st = ST_DUP_TLS; return v; end
    if (p_seen) begin
      if (!fits(p_base, (p_len != 0) ? p_len : 64'd1, 1'b0)) begin
        v.st = ST_PARAMS_MAP;
        return v;
      end
      sum = {1'b0, p_base} + {1'b0, bias};
      if (sum[64]) begin v.st = ST_OVERFLOW; return v; end
      v.hp = 1'b1;
      v.pa = sum[63:0];
    end
    if (t_seen && t_mem != 0) begin
      init = (t_file < t_mem) ? t_file : t_mem;
      if (init != 0 && !fits(t_base, init, 1'b0)) begin v.st = ST_TLS_MAP; return v; end
      sum = {1'b0, t_base} + {1'b0, bias};
      if (sum[64]) begin v.st = ST_OVERFLOW; return v; end
      v.ht = 1'b1;
      v.ta = sum[63:0];
      v.ti = init;
      v.tt = t_mem;
      v.tal = t_align;
    end
    return v;
  endfunction

  task automatic clear_image();
    nseg = 0;
    too_many = 0;
    p_seen = 0;
    t_seen = 0;
    p_base = 0;
    p_len = 0;
    t_base = 0;
    t_file = 0;
    t_mem = 0;
    t_align = 0;
    dup = DUP_NONE;
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    verdicts_seen = 0;
    pending = 0;
    bias = 0;
    entry = 0;
    clear_image();
  end

  always @(posedge clk) begin
    verdict_t w;
    if (rst) begin
      bias = 0;
      entry = 0;
      clear_image();
      verdict_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_BIAS) bias = cfg_data;
        else entry = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (seg_type == TypeLoad) begin
          if (nseg < MaxSegments) begin
            seg_base[nseg] = seg_vaddr;
            seg_len[nseg] = seg_mem_size;
            seg_x[nseg] = seg_exec;
            nseg++;
          end else too_many = 1;
        end else if (seg_type == TypeParams) begin
          if (p_seen) begin
            if (dup == DUP_NONE) dup = DUP_PARAMS;
          end else begin
            p_seen = 1;
            p_base = seg_vaddr;
            p_len = seg_mem_size;
          end
        end else if (seg_type == TypeTls) begin
          if (t_seen) begin
            if (dup == DUP_NONE) dup = DUP_TLS;
          end else begin
            t_seen = 1;
            t_base = seg_vaddr;
            t_file = seg_file_size;
            t_mem = seg_mem_size;
            t_align = seg_align;
          end
        end
        if (last_segment) begin
          verdict_q.push_back(judge_image());
          clear_image();
        end
      end
      if (out_valid && !out_stall) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report("unexpected result beat", '0, '0);
        end else begin
          w = verdict_q.pop_front();
          if (status !== w.st) report("status", 64'(status), 64'(w.st));
          if (entry_valid !== w.he) report("entry_valid", 64'(entry_valid), 64'(w.he));
          if (entry_address !== w.ea) report("entry_address", entry_address, w.ea);
          if (has_params !== w.hp) report("has_params", 64'(has_params), 64'(w.hp));
          if (params_address !== w.pa) report("params_address", params_address, w.pa);
          if (has_tls !== w.ht) report("has_tls", 64'(has_tls), 64'(w.ht));
          if (tls_addr !== w.ta) report("tls_addr", tls_addr, w.ta);
          if (tls_init_size !== w.ti) report("tls_init_size", tls_init_size, w.ti);
          if (tls_total_size !== w.tt) report("tls_total_size", tls_total_size, w.tt);
          if (tls_align !== w.tal) report("tls_align", tls_align, w.tal);
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

// File: tb/sv/load_segment_launch_checker_core_test.sv
module load_segment_launch_checker_core_test;
  import lslc_pkg::*;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall;
  logic [31:0] seg_type = 0;
  logic [63:0] seg_vaddr = 0, seg_mem_size = 0, seg_file_size = 0, seg_align = 0;
  logic        seg_exec = 0, last_segment = 0;
  logic        cfg_we = 0, cfg_idx = 0;
  logic [63:0] cfg_data = 0;
  logic        out_valid, out_stall = 0;
  logic [3:0]  status;
  logic        entry_valid, has_params, has_tls;
  logic [63:0] entry_address, params_address, tls_addr;
  logic [63:0] tls_init_size, tls_total_size, tls_align;
  int          fail_count, pending, verdicts_seen;
  int          headers_sent = 0, idle_cycles = 0;
  logic        calm = 0, hold_rx = 0;
  logic [63:0] img_base;

  load_segment_launch_checker_core dut (.*);
  load_segment_launch_checker_checker chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // receiver stall
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1;
        @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (n) @(negedge clk);
      end else begin
        out_stall <= 0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("timeout");
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up after the beat; callers drop it before pausing
  task automatic send_hdr(logic [31:0] t, logic [63:0] va, logic [63:0] ms,
                          logic [63:0] fs, logic x, logic [63:0] al, logic lst);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1;
    seg_type <= t;
    seg_vaddr <= va;
    seg_mem_size <= ms;
    seg_file_size <= fs;
    seg_exec <= x;
    seg_align <= al;
    last_segment <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    headers_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] pick_val(logic [63:0] near);
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return rnd64();
      3: return near + $urandom_range(0, 64);
      4: return near - $urandom_range(0, 4);
      default: return near + $urandom_range(0, 4096);
    endcase
  endfunction

  // one image: loads around img_base, optional params/TLS, junk, sometimes dups
  task automatic random_image(int nload);
    int          n, kind;
    logic [31:0] t;
    logic [63:0] va, ms;
    n = nload + $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      if (i < nload) t = TypeLoad;
      else if (kind < 6) t = TypeParams;
      else if (kind < 12) t = TypeTls;
      else if (kind < 14) t = $urandom();
      else t = TypeLoad;
      va = pick_val(img_base);
      ms = (kind == 0) ? '1 : (kind == 1 ? 64'd0 : $urandom_range(0, 8192));
      send_hdr(t, va, ms, pick_val(ms), $urandom_range(0, 1), rnd64(), i == n - 1);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed
    write_reg(REG_BIAS, 64'h1000);
    write_reg(REG_ENTRY_OFFSET, 64'h10);
    send_hdr(TypeLoad, 0, 64'h100, 64'h100, 1, 0, 0);
    send_hdr(TypeParams, 64'h20, 0, 0, 0, 0, 0);
    send_hdr(TypeTls, 64'h40, 64'h30, 64'h50, 0, 64'h8, 1);
    send_hdr(TypeLoad, 0, 64'h100, 0, 0, 0, 1);
    send_hdr(32'h5, 0, 0, 0, 0, 0, 1);
    send_hdr(TypeLoad, 0, 64'h100, 0, 1, 0, 0);
    send_hdr(TypeTls, 64'h10, 1, 0, 0, '1, 0);
    send_hdr(TypeTls, 64'h10, 1, 0, 0, 0, 0);
    send_hdr(TypeParams, 64'h10, 1, 0, 0, 0, 1);
    send_hdr(TypeLoad, 0, 64'h100, 0, 1, 0, 0);
    send_hdr(TypeParams, 64'h200, 1, 0, 0, 0, 1);
    drain();
    write_reg(REG_BIAS, '1);
    write_reg(REG_ENTRY_OFFSET, 0);
    send_hdr(TypeLoad, 0, '1, '1, 1, '1, 0);
    send_hdr(TypeParams, 0, 0, 0, 0, 0, 1);
    send_hdr(TypeLoad, '1, 0, 0, 0, 0, 0);
    send_hdr(TypeTls, '1, 0, '1, 0, '1, 1);
    for (int i = 0; i < 66; i++)
      send_hdr(TypeLoad, i, 1, 0, i[0], 0, i == 65);
    drain();

    // random phases with varied register settings
    for (int ph = 0; ph < 8; ph++) begin
      img_base = (ph % 3 == 0) ? 64'd0 : ((ph % 3 == 1) ? 64'hFFFF_FFFF_FFFF_0000 : rnd64());
      write_reg(REG_BIAS, (ph == 1) ? 64'd0 : ((ph == 2) ? '1 : pick_val(64'h4000)));
      write_reg(REG_ENTRY_OFFSET, (ph == 3) ? 64'd0 : ((ph == 4) ? '1 : pick_val(img_base)));
      if (ph == 7) calm = 1;
      if (ph == 2) begin
        hold_rx = 1;
        fork
          begin
            repeat (400) @(negedge clk);
            hold_rx = 0;
          end
        join_none
      end
      while (headers_sent < 155 * (ph + 1) + 100) begin
        random_image(($urandom_range(0, 30) == 0) ? 64 + $urandom_range(0, 2)
                                                    : $urandom_range(0, 5));
        if (ph == 5 && headers_sent % 3 == 0) begin
          in_valid <= 0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end
    $display("covered %0d headers and %0d results across 10 register settings",
             headers_sent, verdicts_seen);
    $display("including store overflow, duplicates, rebase overflow and receiver hold-off");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
